// ===== rtl/tidbe_pkg.sv =====
// package for the triple input debounce event block
// payload structs, event codes, register indexes and reset values; no dependencies
`default_nettype none

package tidbe_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DEBOUNCE_W = 16;
    localparam int unsigned CFG_IDX_W  = 8;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_TRIGGERED = 2'd1,
        EV_CLEARED   = 2'd2,
        EV_BOTH_SW   = 2'd3
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SWITCH_DEBOUNCE = 8'd0,
        REG_PHOTO_DEBOUNCE  = 8'd1
    } t_reg_idx;

    localparam logic [DEBOUNCE_W-1:0] SWITCH_DEBOUNCE_RST = 16'd50;
    localparam logic [DEBOUNCE_W-1:0] PHOTO_DEBOUNCE_RST  = 16'd20;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              closed_switch_pin;
        logic              open_switch_pin;
        logic              photocell_pin;
    } t_scan;

    typedef struct packed {
        logic [1:0] event_res;
        logic       closed_switch_active;
        logic       open_switch_active;
        logic       photocell_active;
    } t_result;

    typedef struct packed {
        logic stable;
        logic changed;
    } t_chan_status;

endpackage

`default_nettype wire

// ===== rtl/triple_input_debounce_events.sv =====
// top level of the triple input debounce event block
// depends on tidbe_pkg and tidbe_channel
//
// One scan is accepted per clock and its result appears in the output register on the
// next cycle; a new scan is taken whenever the output register is empty or being read,
// so the sustained rate is one scan per cycle. Each channel does one 32-bit wrapping
// subtract and compare against its debounce time. Both limit switches reset to pressed,
// so results report the both-switches event until one of them debounces to released.
// Configuration writes are always accepted; unknown indexes are ignored.
`default_nettype none

module triple_input_debounce_events (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_scan_valid,
    output logic                                    o_scan_ready,
    input  wire tidbe_pkg::t_scan                   i_scan,
    output logic                                    o_res_valid,
    input  wire logic                               i_res_ready,
    output tidbe_pkg::t_result                      o_res,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [tidbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tidbe_pkg::DEBOUNCE_W-1:0]   i_cfg_data
);

    logic [tidbe_pkg::DEBOUNCE_W-1:0] r_switch_db;
    logic [tidbe_pkg::DEBOUNCE_W-1:0] r_photo_db;
    logic                             r_res_valid;
    tidbe_pkg::t_result               r_res;
    tidbe_pkg::t_result               n_res;
    tidbe_pkg::t_chan_status          closed_st;
    tidbe_pkg::t_chan_status          open_st;
    tidbe_pkg::t_chan_status          photo_st;
    logic                             scan_acc;

    assign o_scan_ready = !r_res_valid || i_res_ready;
    assign scan_acc     = i_scan_valid && o_scan_ready;
    assign o_cfg_ready  = 1'b1;

    // pins are active low
    tidbe_channel u_closed (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (scan_acc),
        .i_raw    (!i_scan.closed_switch_pin),
        .i_now    (i_scan.now_ms),
        .i_limit  (r_switch_db),
        .o_status (closed_st)
    );

    tidbe_channel u_open (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (scan_acc),
        .i_raw    (!i_scan.open_switch_pin),
        .i_now    (i_scan.now_ms),
        .i_limit  (r_switch_db),
        .o_status (open_st)
    );

    tidbe_channel u_photo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (scan_acc),
        .i_raw    (!i_scan.photocell_pin),
        .i_now    (i_scan.now_ms),
        .i_limit  (r_photo_db),
        .o_status (photo_st)
    );

    always_comb begin
        n_res.event_res = tidbe_pkg::EV_NONE;
        if (photo_st.changed) begin
            n_res.event_res = photo_st.stable ? tidbe_pkg::EV_TRIGGERED
                                              : tidbe_pkg::EV_CLEARED;
        end
        if (closed_st.stable && open_st.stable) begin
            n_res.event_res = tidbe_pkg::EV_BOTH_SW;
        end
        n_res.closed_switch_active = closed_st.stable;
        n_res.open_switch_active   = open_st.stable;
        n_res.photocell_active     = photo_st.stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch_db <= tidbe_pkg::SWITCH_DEBOUNCE_RST;
            r_photo_db  <= tidbe_pkg::PHOTO_DEBOUNCE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tidbe_pkg::REG_SWITCH_DEBOUNCE: begin
                    r_switch_db <= i_cfg_data;
                end
                tidbe_pkg::REG_PHOTO_DEBOUNCE: begin
                    r_photo_db <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (scan_acc) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_acc) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== rtl/tidbe_channel.sv =====
// one debounce channel: stable state and time of last agreement
// uses tidbe_pkg for widths and the status struct
`default_nettype none

module tidbe_channel (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_raw,
    input  wire logic [tidbe_pkg::TIME_W-1:0]        i_now,
    input  wire logic [tidbe_pkg::DEBOUNCE_W-1:0]    i_limit,
    output tidbe_pkg::t_chan_status                  o_status
);

    logic                          r_stable;
    logic [tidbe_pkg::TIME_W-1:0]  r_agree;
    logic                          n_stable;
    logic [tidbe_pkg::TIME_W-1:0]  n_agree;
    logic [tidbe_pkg::TIME_W-1:0]  elapsed;
    logic                          changed;

    always_comb begin
        elapsed  = i_now - r_agree;
        n_stable = r_stable;
        n_agree  = r_agree;
        changed  = 1'b0;
        if (i_raw != r_stable) begin
            if (elapsed >= {{(tidbe_pkg::TIME_W-tidbe_pkg::DEBOUNCE_W){1'b0}}, i_limit}) begin
                n_stable = i_raw;
                n_agree  = i_now;
                changed  = 1'b1;
            end
        end else begin
            n_agree = i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_agree  <= '0;
        end else if (i_en) begin
            r_stable <= n_stable;
            r_agree  <= n_agree;
        end
    end

    assign o_status.stable  = n_stable;
    assign o_status.changed = changed;

endmodule

`default_nettype wire
